### hdl/lbcs_pkg.sv
`default_nettype none

package lbcs_pkg;

  localparam int TIME_W   = 32;
  localparam int CODE_W   = 8;
  localparam int IVL_W    = 11;
  localparam int POS_W    = 7;
  localparam int NUM_REGS = 3;
  localparam int REG_IDX_W = 2;

  localparam logic [IVL_W-1:0] LONG_MS  = IVL_W'(2000);
  localparam logic [IVL_W-1:0] SHORT_MS = IVL_W'(500);

  // config register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_RED    = 2'd0,
    REG_YELLOW = 2'd1,
    REG_BLUE   = 2'd2
  } reg_idx_t;

  // Blink pattern bit at a position: each set code bit k moves the running
  // sum by 2(k+1) and marks sum-1 long; the terminator sits at the final sum.
  function automatic logic pattern_bit(input logic [CODE_W-1:0] code,
                                       input logic [POS_W-1:0] pos);
    logic [POS_W-1:0] sum;
    logic             hit;
    sum = '0;
    hit = 1'b0;
    for (int k = 0; k < CODE_W; k++) begin
      if (code[k]) begin
        sum = sum + POS_W'(2 * (k + 1));
        if (pos == sum - POS_W'(1)) begin
          hit = 1'b1;
        end
      end
    end
    return hit | (pos == sum);
  endfunction

endpackage

`default_nettype wire

### hdl/lbcs_if.sv
`default_nettype none

interface lbcs_time_if;
  logic                          valid;
  logic                          ready;
  logic [lbcs_pkg::TIME_W-1:0]   time_ms;

  modport source(output valid, output time_ms, input ready);
  modport sink(input valid, input time_ms, output ready);
endinterface

interface lbcs_led_if;
  logic valid;
  logic ready;
  logic red_on;
  logic yellow_on;
  logic blue_on;

  modport source(output valid, output red_on, output yellow_on, output blue_on,
                 input ready);
  modport sink(input valid, input red_on, input yellow_on, input blue_on,
               output ready);
endinterface

`default_nettype wire

### hdl/led_blink_code_sequencer_unit.sv
`default_nettype none

// LED blink code sequencer. Each word on time_in carries the current time in
// milliseconds; for each word one word leaves on led_out with the red, yellow
// and blue LED levels after that time step. Blink codes are written through
// write_en/write_index/write_data (index 0 red, 1 yellow, 2 blue, 8 bits each,
// zero disables a channel); write them only while no word is in flight.
// Throughput is one word per clock while led_out is not stalled. A result
// passes through the input register, then the per-channel state update
// feeding the output register, before it is on led_out. Both sides may
// stall freely.
module led_blink_code_sequencer_unit #(
  parameter int NUM_CHANNELS = 3
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               write_en,
  input  wire logic [lbcs_pkg::REG_IDX_W-1:0]     write_index,
  input  wire logic [lbcs_pkg::CODE_W-1:0]        write_data,
  lbcs_time_if.sink                               time_in,
  lbcs_led_if.source                              led_out
);

  // channels past the register list never light an output
  localparam int NUM_ACTIVE =
    (NUM_CHANNELS < lbcs_pkg::NUM_REGS) ? NUM_CHANNELS : lbcs_pkg::NUM_REGS;

  logic [lbcs_pkg::CODE_W-1:0] codes [NUM_ACTIVE];
  logic [NUM_ACTIVE-1:0]       led_next;
  logic [lbcs_pkg::NUM_REGS-1:0] led_pad;

  logic                        hold_valid;
  logic [lbcs_pkg::TIME_W-1:0] hold_time;
  logic                        proc;
  logic                        out_valid;
  logic [lbcs_pkg::NUM_REGS-1:0] out_leds;

  assign proc          = hold_valid && (!out_valid || led_out.ready);
  assign time_in.ready = !hold_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ACTIVE; i++) begin
        codes[i] <= '0;
      end
    end else if (write_en) begin
      for (int i = 0; i < NUM_ACTIVE; i++) begin
        if (write_index == lbcs_pkg::REG_IDX_W'(i)) begin
          codes[i] <= write_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (time_in.ready) begin
      hold_valid <= time_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (time_in.valid && time_in.ready) begin
      hold_time <= time_in.time_ms;
    end
  end

  for (genvar c = 0; c < NUM_ACTIVE; c++) begin : g_chan
    lbcs_chan u_chan (
      .clk      (clk),
      .rst      (rst),
      .step     (proc),
      .time_ms  (hold_time),
      .code     (codes[c]),
      .led_next (led_next[c])
    );
  end

  for (genvar j = 0; j < lbcs_pkg::NUM_REGS; j++) begin : g_pad
    if (j < NUM_ACTIVE) begin : g_live
      assign led_pad[j] = led_next[j];
    end else begin : g_zero
      assign led_pad[j] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc) begin
      out_valid <= 1'b1;
    end else if (led_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_leds <= led_pad;
    end
  end

  assign led_out.valid     = out_valid;
  assign led_out.red_on    = out_leds[lbcs_pkg::REG_RED];
  assign led_out.yellow_on = out_leds[lbcs_pkg::REG_YELLOW];
  assign led_out.blue_on   = out_leds[lbcs_pkg::REG_BLUE];

endmodule

`default_nettype wire

### hdl/lbcs_chan.sv
`default_nettype none

module lbcs_chan (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          step,
  input  wire logic [lbcs_pkg::TIME_W-1:0]   time_ms,
  input  wire logic [lbcs_pkg::CODE_W-1:0]   code,
  output logic                               led_next
);

  logic [lbcs_pkg::TIME_W-1:0] last_change_time, last_change_time_next;
  logic [lbcs_pkg::IVL_W-1:0]  wait_interval, wait_interval_next;
  logic [lbcs_pkg::POS_W-1:0]  bit_position, bit_position_next;
  logic                        last_was_long, last_was_long_next;
  logic                        led_level;

  logic [lbcs_pkg::TIME_W-1:0] elapsed;
  logic                        due;
  logic                        pbit;

  assign elapsed = time_ms - last_change_time;
  assign due     = elapsed >= lbcs_pkg::TIME_W'(wait_interval);
  assign pbit    = lbcs_pkg::pattern_bit(code, bit_position);

  always_comb begin
    last_change_time_next = last_change_time;
    wait_interval_next    = wait_interval;
    bit_position_next     = bit_position;
    last_was_long_next    = last_was_long;
    led_next              = led_level;
    if (step && due) begin
      last_change_time_next = time_ms;
      if (code != '0) begin
        if (pbit && last_was_long) begin
          // two longs in a row: restart now, serviced again on the next word
          bit_position_next  = '0;
          wait_interval_next = '0;
          last_was_long_next = 1'b0;
        end else begin
          bit_position_next  = bit_position + lbcs_pkg::POS_W'(1);
          wait_interval_next = pbit ? lbcs_pkg::LONG_MS : lbcs_pkg::SHORT_MS;
          last_was_long_next = pbit;
          led_next           = ~led_level;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_change_time <= '0;
      wait_interval    <= '0;
      bit_position     <= '0;
      last_was_long    <= 1'b0;
      led_level        <= 1'b0;
    end else begin
      last_change_time <= last_change_time_next;
      wait_interval    <= wait_interval_next;
      bit_position     <= bit_position_next;
      last_was_long    <= last_was_long_next;
      led_level        <= led_next;
    end
  end

endmodule

`default_nettype wire

### bench/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH = 3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PHASE = 180;
  // no register behind it
  localparam logic [lbcs_pkg::REG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic red;
    logic yellow;
    logic blue;
  } led_word_t;

  logic clk = 1'b0;
  logic rst;
  logic write_en;
  logic [lbcs_pkg::REG_IDX_W-1:0] write_index;
  logic [lbcs_pkg::CODE_W-1:0] write_data;

  lbcs_time_if time_bus();
  lbcs_led_if led_bus();

  led_blink_code_sequencer_unit #(.NUM_CHANNELS(NCH)) i_dut (
    .clk(clk),
    .rst(rst),
    .write_en(write_en),
    .write_index(write_index),
    .write_data(write_data),
    .time_in(time_bus),
    .led_out(led_bus)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predicted sequencer state, one entry per channel
  logic [lbcs_pkg::CODE_W-1:0] code_m [NCH];
  logic [lbcs_pkg::TIME_W-1:0] stamp_m [NCH];
  logic [lbcs_pkg::IVL_W-1:0] ivl_m [NCH];
  logic [lbcs_pkg::POS_W-1:0] pos_m [NCH];
  logic was_long_m [NCH];
  logic lit_m [NCH];

  logic [lbcs_pkg::TIME_W-1:0] time_pending [$];
  led_word_t led_expect [$];
  int n_queued = 0;
  int n_accepted = 0;
  int errors = 0;
  int cycles = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;

  function automatic logic blink_bit(logic [lbcs_pkg::CODE_W-1:0] code,
                                     logic [lbcs_pkg::POS_W-1:0] pos);
    int unsigned run;
    run = 0;
    for (int k = 0; k < lbcs_pkg::CODE_W; k++) begin
      if (code[k]) begin
        run += 2 * (k + 1);
        if (pos == run - 1) return 1'b1;
      end
    end
    return pos == run;
  endfunction

  function automatic led_word_t advance_leds(logic [lbcs_pkg::TIME_W-1:0] now);
    logic b;
    led_word_t w;
    for (int ch = 0; ch < NCH; ch++) begin
      if (lbcs_pkg::TIME_W'(now - stamp_m[ch]) >= lbcs_pkg::TIME_W'(ivl_m[ch])) begin
        stamp_m[ch] = now;
        if (code_m[ch] != '0) begin
          b = blink_bit(code_m[ch], pos_m[ch]);
          pos_m[ch] = pos_m[ch] + lbcs_pkg::POS_W'(1);
          ivl_m[ch] = b ? lbcs_pkg::LONG_MS : lbcs_pkg::SHORT_MS;
          if (b && was_long_m[ch]) begin
            // back-to-back long marks: restart, serviced again next word
            pos_m[ch] = '0;
            ivl_m[ch] = '0;
            was_long_m[ch] = 1'b0;
          end else begin
            was_long_m[ch] = b;
            lit_m[ch] = ~lit_m[ch];
          end
        end
      end
    end
    w.red = lit_m[0];
    w.yellow = lit_m[1];
    w.blue = lit_m[2];
    return w;
  endfunction

  // mostly forward-moving time, some exact interval edges, some wild jumps
  function automatic logic [lbcs_pkg::TIME_W-1:0] next_time(logic [lbcs_pkg::TIME_W-1:0] t);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return $urandom();
    if (r < 16) return t;
    if (r < 30) begin
      case ($urandom_range(3))
        0: return t + 499;
        1: return t + 500;
        2: return t + 1999;
        default: return t + 2000;
      endcase
    end
    return t + $urandom_range(2600);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      time_bus.valid <= 1'b0;
    end else begin
      if (time_bus.valid && time_bus.ready) begin
        led_expect.push_back(advance_leds(time_bus.time_ms));
        n_accepted++;
      end
      if (!time_bus.valid || time_bus.ready) begin
        if (time_pending.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          time_bus.valid <= 1'b1;
          time_bus.time_ms <= time_pending.pop_front();
        end else begin
          time_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    led_word_t exp_w;
    if (rst) begin
      led_bus.ready <= 1'b0;
    end else begin
      if (led_bus.valid && led_bus.ready) begin
        if (led_expect.size() == 0) begin
          $display("%0t unexpected word red %0b yellow %0b blue %0b", $time,
                   led_bus.red_on, led_bus.yellow_on, led_bus.blue_on);
          errors++;
        end else begin
          exp_w = led_expect.pop_front();
          if (led_bus.red_on !== exp_w.red) begin
            $display("%0t red_on expected %0b got %0b", $time, exp_w.red, led_bus.red_on);
            errors++;
          end
          if (led_bus.yellow_on !== exp_w.yellow) begin
            $display("%0t yellow_on expected %0b got %0b", $time, exp_w.yellow,
                     led_bus.yellow_on);
            errors++;
          end
          if (led_bus.blue_on !== exp_w.blue) begin
            $display("%0t blue_on expected %0b got %0b", $time, exp_w.blue, led_bus.blue_on);
            errors++;
          end
        end
      end
      led_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout, %0d words outstanding", $time, led_expect.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic set_code(logic [lbcs_pkg::REG_IDX_W-1:0] idx,
                          logic [lbcs_pkg::CODE_W-1:0] val);
    @(posedge clk);
    write_en <= 1'b1;
    write_index <= idx;
    write_data <= val;
    @(posedge clk);
    write_en <= 1'b0;
    if (idx < NCH) code_m[idx] = val;
  endtask

  task automatic push_time(logic [lbcs_pkg::TIME_W-1:0] t);
    time_pending.push_back(t);
    n_queued++;
  endtask

  task automatic drain();
    while (n_accepted != n_queued || led_expect.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [lbcs_pkg::TIME_W-1:0] cur;
    int offs [14];
    offs = '{0, 499, 500, 1000, 1500, 1999, 2000, 2500, 4500, 4501, 5000, 7000, 7001, 7500};
    rst = 1'b1;
    write_en = 1'b0;
    write_index = '0;
    write_data = '0;
    time_bus.valid = 1'b0;
    time_bus.time_ms = '0;
    led_bus.ready = 1'b0;
    for (int ch = 0; ch < NCH; ch++) begin
      code_m[ch] = '0;
      stamp_m[ch] = '0;
      ivl_m[ch] = '0;
      pos_m[ch] = '0;
      was_long_m[ch] = 1'b0;
      lit_m[ch] = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // all channels disabled: times get recorded, LEDs stay dark
    push_time(32'h0000_0000);
    push_time(32'hFFFF_FFFF);
    push_time(32'h0000_0001);
    push_time(32'h8000_0000);
    drain();

    // longest, shortest and single-high-bit codes; time wraps mid-run
    set_code(lbcs_pkg::REG_RED, 8'hFF);
    set_code(lbcs_pkg::REG_YELLOW, 8'h01);
    set_code(lbcs_pkg::REG_BLUE, 8'h80);
    set_code(REG_SPARE, 8'h5A);
    for (int i = 0; i < 14; i++) push_time(32'hFFFF_F800 + offs[i]);
    drain();
    cur = 32'hFFFF_F800 + offs[13];

    for (int p = 0; p < 6; p++) begin
      case (p)
        1: begin
          set_code(lbcs_pkg::REG_RED, 8'hFF);
          set_code(lbcs_pkg::REG_YELLOW, 8'h80);
          set_code(lbcs_pkg::REG_BLUE, 8'h01);
        end
        2: begin
          // short code mid-sequence: position runs past the terminator and wraps
          set_code(lbcs_pkg::REG_RED, 8'h01);
          set_code(lbcs_pkg::REG_YELLOW, 8'h00);
          set_code(lbcs_pkg::REG_BLUE, lbcs_pkg::CODE_W'($urandom_range(1, 255)));
        end
        4: begin
          set_code(lbcs_pkg::REG_RED, 8'h00);
          set_code(lbcs_pkg::REG_YELLOW, 8'hFF);
          set_code(lbcs_pkg::REG_BLUE, 8'h55);
        end
        default: begin
          set_code(lbcs_pkg::REG_RED, ($urandom_range(3) == 0) ? 8'h00 :
                   lbcs_pkg::CODE_W'($urandom_range(1, 255)));
          set_code(lbcs_pkg::REG_YELLOW, lbcs_pkg::CODE_W'($urandom_range(255)));
          set_code(lbcs_pkg::REG_BLUE, lbcs_pkg::CODE_W'($urandom_range(1, 255)));
        end
      endcase
      set_code(REG_SPARE, lbcs_pkg::CODE_W'($urandom_range(255)));
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 58; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 58; end
        default: begin src_idle_pct = 36; snk_stall_pct = 36; end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        cur = next_time(cur);
        push_time(cur);
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (led_expect.size() != 0) errors++;
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
